// File: rtl/interval_spray_timer_controller_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the interval spray timer controller
// ----------------------------------------------------------------------------
`ifndef INTERVAL_SPRAY_TIMER_CONTROLLER_CORE_ASSERT_SVH
`define INTERVAL_SPRAY_TIMER_CONTROLLER_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define ISCT_ASSERT_IMPL(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset
`define ISCT_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/isct_pkg.sv
// ----------------------------------------------------------------------------
// isct_pkg
// Shared constants, types and helper functions of the spray timer controller.
// ----------------------------------------------------------------------------
package isct_pkg;

    localparam int unsigned MS_PER_SECOND      = 1000;
    localparam int unsigned SECONDS_PER_MINUTE = 60;
    localparam int unsigned MINUTES_MAX        = 99;

    localparam int unsigned MS_W     = 10;
    localparam int unsigned SEC_W    = 6;
    localparam int unsigned MIN_W    = 7;
    localparam int unsigned DUR_W    = 16;
    localparam int unsigned CFG_W    = 16;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned LED_W    = 5;
    localparam int unsigned SEG_W    = 8;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_INTERVAL_MINUTES = 3'd0,
        CFG_SPRAY_MS_LOW     = 3'd1,
        CFG_SPRAY_MS_MID     = 3'd2,
        CFG_SPRAY_MS_HIGH    = 3'd3,
        CFG_BOOST_MS         = 3'd4
    } cfg_idx_t;

    typedef enum logic [1:0] {
        LEVEL_IDLE = 2'd0,
        LEVEL_LOW  = 2'd1,
        LEVEL_MID  = 2'd2,
        LEVEL_HIGH = 2'd3
    } level_t;

    typedef struct packed {
        logic             spray_on;
        logic [LED_W-1:0] level_leds;
        logic             power_on;
        logic             heartbeat;
        logic [SEG_W-1:0] seg_tens;
        logic [SEG_W-1:0] seg_ones;
    } result_t;

    // Active-low seven-segment pattern for one decimal digit
    function automatic logic [SEG_W-1:0] seg_code(input logic [3:0] digit);
        logic [SEG_W-1:0] code;
        case (digit)
            4'd0:    code = 8'hc0;
            4'd1:    code = 8'hf9;
            4'd2:    code = 8'ha4;
            4'd3:    code = 8'hb0;
            4'd4:    code = 8'h99;
            4'd5:    code = 8'h92;
            4'd6:    code = 8'h82;
            4'd7:    code = 8'hf8;
            4'd8:    code = 8'h80;
            4'd9:    code = 8'h90;
            default: code = 8'hff;
        endcase
        return code;
    endfunction

    // Tens digit of a value up to 99: multiply by 103/1024
    function automatic logic [3:0] tens_digit(input logic [MIN_W-1:0] value);
        logic [13:0] prod;
        prod = 14'(value) * 14'd103;
        return prod[13:10];
    endfunction

endpackage

// File: rtl/isct_ifs.sv
// ----------------------------------------------------------------------------
// isct channel interfaces
// Valid/ready channels for the per-millisecond button sample and the result.
// ----------------------------------------------------------------------------
interface isct_tick_if;
    logic valid;
    logic ready;
    logic level_button;
    logic boost_button;
    logic power_button;

    modport source (output valid, output level_button, output boost_button,
                    output power_button, input ready);
    modport sink   (input valid, input level_button, input boost_button,
                    input power_button, output ready);
endinterface

interface isct_status_if;
    logic       valid;
    logic       ready;
    logic       spray_on;
    logic [4:0] level_leds;
    logic       power_on;
    logic       heartbeat;
    logic [7:0] seg_tens;
    logic [7:0] seg_ones;

    modport source (output valid, output spray_on, output level_leds, output power_on,
                    output heartbeat, output seg_tens, output seg_ones, input ready);
    modport sink   (input valid, input spray_on, input level_leds, input power_on,
                    input heartbeat, input seg_tens, input seg_ones, output ready);
endinterface

// File: rtl/interval_spray_timer_controller_core.sv
// The status of an accepted request stands on the output register in the next cycle.
// Throughput: one request per cycle while the sink takes each status; the next-state
// update of the timebase and spray counters is done in one pass between request and result.
// A request is taken while a finished status waits, as long as that status leaves.
// Reset (rst_n low, asynchronous) clears all counters, level, spray and button state
// and loads the register defaults; no clearing pass follows.
// ----------------------------------------------------------------------------
// interval_spray_timer_controller_core
// Millisecond timebase, level and boost spray control, seven-segment minutes.
// ----------------------------------------------------------------------------
module interval_spray_timer_controller_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [isct_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [isct_pkg::CFG_W-1:0]     cfg_data,
    isct_tick_if.sink                     tick,
    isct_status_if.source                 status
);
    import isct_pkg::*;

    `include "interval_spray_timer_controller_core_assert.svh"

    // configuration
    logic [MIN_W-1:0] interval_reg;
    logic [DUR_W-1:0] spray_low_reg;
    logic [DUR_W-1:0] spray_mid_reg;
    logic [DUR_W-1:0] spray_high_reg;
    logic [DUR_W-1:0] boost_reg;

    // state
    logic [MS_W-1:0]  ms_reg,        ms_next;
    logic [SEC_W-1:0] sec_reg,       sec_next;
    logic [MIN_W-1:0] min_reg,       min_next;
    level_t           level_reg,     level_next;
    logic [DUR_W-1:0] spray_left_reg, spray_left_next;
    logic             boosting_reg,  boosting_next;
    logic             prev_lvl_reg,  prev_pwr_reg;
    logic             power_reg,     power_next;
    logic             hb_reg,        hb_next;

    result_t          result_reg,    result_next;
    logic             out_valid_reg;

    logic             accept;
    logic [MS_W:0]    ms_inc;
    logic             sec_tick;
    logic [SEC_W-1:0] sec_inc;
    logic             min_tick;
    logic [3:0]       tens;
    logic [3:0]       ones;
    logic [MIN_W-1:0] tens_x10;

    assign tick.ready = !out_valid_reg || status.ready;
    assign accept     = tick.valid && tick.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            interval_reg   <= MIN_W'(15);
            spray_low_reg  <= DUR_W'(1500);
            spray_mid_reg  <= DUR_W'(3000);
            spray_high_reg <= DUR_W'(6000);
            boost_reg      <= DUR_W'(15000);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_INTERVAL_MINUTES: interval_reg   <= cfg_data[MIN_W-1:0];
                CFG_SPRAY_MS_LOW:     spray_low_reg  <= cfg_data[DUR_W-1:0];
                CFG_SPRAY_MS_MID:     spray_mid_reg  <= cfg_data[DUR_W-1:0];
                CFG_SPRAY_MS_HIGH:    spray_high_reg <= cfg_data[DUR_W-1:0];
                CFG_BOOST_MS:         boost_reg      <= cfg_data[DUR_W-1:0];
                default:              ;
            endcase
        end
    end

    // timebase
    assign ms_inc   = {1'b0, ms_reg} + (MS_W+1)'(1);
    assign sec_tick = (ms_inc >= (MS_W+1)'(MS_PER_SECOND));
    assign sec_inc  = sec_reg + SEC_W'(1);
    assign min_tick = sec_tick && (sec_inc >= SEC_W'(SECONDS_PER_MINUTE));

    always_comb
    begin
        ms_next         = sec_tick ? '0 : ms_inc[MS_W-1:0];
        hb_next         = hb_reg ^ sec_tick;
        sec_next        = sec_reg;
        min_next        = min_reg;
        level_next      = level_reg;
        spray_left_next = spray_left_reg;
        boosting_next   = boosting_reg;
        power_next      = power_reg;

        if (sec_tick)
        begin
            sec_next = min_tick ? '0 : sec_inc;
        end
        if (min_tick && (min_reg < MIN_W'(MINUTES_MAX)))
        begin
            min_next = min_reg + MIN_W'(1);
        end

        if (spray_left_reg != '0)
        begin
            spray_left_next = spray_left_reg - DUR_W'(1);
            if ((spray_left_next == '0) && boosting_reg)
            begin
                boosting_next = 1'b0;
                level_next    = LEVEL_IDLE;
                min_next      = '0;
            end
        end
        else
        begin
            if (tick.level_button && !prev_lvl_reg)
            begin
                level_next = level_t'(level_reg + 2'd1);
            end
            if (tick.power_button && !prev_pwr_reg)
            begin
                power_next = !power_reg;
            end
            if (tick.boost_button)
            begin
                spray_left_next = boost_reg;
                boosting_next   = (boost_reg != '0);
                if (boost_reg == '0)
                begin
                    level_next = LEVEL_IDLE;
                    min_next   = '0;
                end
            end
            else if ((level_next != LEVEL_IDLE) && (min_next >= interval_reg))
            begin
                min_next = '0;
                case (level_next)
                    LEVEL_LOW: spray_left_next = spray_low_reg;
                    LEVEL_MID: spray_left_next = spray_mid_reg;
                    default:   spray_left_next = spray_high_reg;
                endcase
            end
        end
    end

    // status digits
    assign tens     = tens_digit(min_next);
    assign tens_x10 = MIN_W'({tens, 3'b000}) + MIN_W'({tens, 1'b0});
    assign ones     = 4'(min_next - tens_x10);

    always_comb
    begin
        result_next.spray_on   = (spray_left_next != '0);
        result_next.level_leds = boosting_next ? LED_W'(5'b10000)
                                               : (LED_W'(1) << level_next);
        result_next.power_on   = power_next;
        result_next.heartbeat  = hb_next;
        result_next.seg_tens   = seg_code(tens);
        result_next.seg_ones   = seg_code(ones);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ms_reg         <= '0;
            sec_reg        <= '0;
            min_reg        <= '0;
            level_reg      <= LEVEL_IDLE;
            spray_left_reg <= '0;
            boosting_reg   <= 1'b0;
            prev_lvl_reg   <= 1'b0;
            prev_pwr_reg   <= 1'b0;
            power_reg      <= 1'b0;
            hb_reg         <= 1'b0;
        end
        else if (accept)
        begin
            ms_reg         <= ms_next;
            sec_reg        <= sec_next;
            min_reg        <= min_next;
            level_reg      <= level_next;
            spray_left_reg <= spray_left_next;
            boosting_reg   <= boosting_next;
            prev_lvl_reg   <= tick.level_button;
            prev_pwr_reg   <= tick.power_button;
            power_reg      <= power_next;
            hb_reg         <= hb_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (status.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // hold the status while the sink stalls
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            result_reg <= result_next;
        end
    end

    assign status.valid      = out_valid_reg;
    assign status.spray_on   = result_reg.spray_on;
    assign status.level_leds = result_reg.level_leds;
    assign status.power_on   = result_reg.power_on;
    assign status.heartbeat  = result_reg.heartbeat;
    assign status.seg_tens   = result_reg.seg_tens;
    assign status.seg_ones   = result_reg.seg_ones;

    `ISCT_ASSERT_IMPL(a_boost_needs_spray, clk, rst_n, boosting_reg, spray_left_reg != '0, "boost flag set with no spray running")
    `ISCT_ASSERT_NEXT(a_accept_loads_status, clk, rst_n, accept, out_valid_reg, "accepted request left no status")
    `ISCT_ASSERT_IMPL(a_leds_onehot, clk, rst_n, out_valid_reg, $onehot(result_reg.level_leds), "level LEDs not one-hot")
    `ISCT_ASSERT_IMPL(a_minutes_capped, clk, rst_n, 1'b1, min_reg <= MIN_W'(MINUTES_MAX), "minute count above cap")

endmodule
